[hdl/uvs_pkg.sv]
// shared types, constants and helper functions for the uv sphere vertex generator
package uvs_pkg;

	// cordic datapath
	localparam int CQ        = 30;
	localparam int CW        = 34;
	localparam int CORD_STG  = 10;
	localparam int CORD_IPS  = 3;
	localparam int DIV_STG   = 4;

	typedef logic signed [CW-1:0] cword_t;

	localparam logic [30:0] ONE_Q30     = 31'd1073741824;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam cword_t      CORD_GAIN   = 34'sd652032874;

	// result queue
	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// register file
	localparam int          ADDR_W        = 3;
	localparam logic [0:0]  REG_PRECISION = 1'b0;
	localparam logic [7:0]  PREC_RESET    = 8'd48;

	typedef enum logic [1:0] {
		KIND_NORMAL   = 2'd0,
		KIND_POSITION = 2'd1,
		KIND_TRIANGLE = 2'd2,
		KIND_ERROR    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		BEAT_NORMAL,
		BEAT_POSITION,
		BEAT_TRI_LO,
		BEAT_TRI_HI
	} beat_t;

	// octant reduction of one angle
	typedef struct packed {
		logic [1:0] q;
		logic       sw;
		logic       zr;
		logic [8:0] t;
	} prep_t;

	typedef struct packed {
		logic [30:0] cm;
		logic        cn;
		logic [30:0] sm;
		logic        sn;
	} trig_t;

	// per-item control that rides alongside the arithmetic
	typedef struct packed {
		logic        err;
		logic        trg;
		logic [15:0] base;
		logic [8:0]  w;
		logic [1:0]  qa;
		logic        swa;
		logic        za;
		logic [1:0]  qb;
		logic        swb;
		logic        zb;
	} side_t;

	typedef struct packed {
		logic        err;
		logic        trg;
		logic [18:0] nx;
		logic [18:0] ny;
		logic [18:0] nz;
		logic [18:0] px;
		logic [18:0] py;
		logic [18:0] pz;
		logic [16:0] tu;
		logic [16:0] tv;
		logic [15:0] base;
		logic [8:0]  w;
	} res_t;

	function automatic cword_t atan_q30(input int i);
		logic [31:0] a;
		case (i)
			0:  a = 32'h3243F6A8;
			1:  a = 32'h1DAC6705;
			2:  a = 32'h0FADBAFC;
			3:  a = 32'h07F56EA6;
			4:  a = 32'h03FEAB76;
			5:  a = 32'h01FFD55B;
			6:  a = 32'h00FFFAAA;
			7:  a = 32'h007FFF55;
			8:  a = 32'h003FFFEA;
			9:  a = 32'h001FFFFD;
			10: a = 32'h000FFFFF;
			11: a = 32'h0007FFFF;
			12: a = 32'h0003FFFF;
			13: a = 32'h0001FFFF;
			14: a = 32'h0000FFFF;
			15: a = 32'h00007FFF;
			16: a = 32'h00003FFF;
			17: a = 32'h00001FFF;
			18: a = 32'h00000FFF;
			19: a = 32'h000007FF;
			20: a = 32'h000003FF;
			21: a = 32'h000001FF;
			22: a = 32'h000000FF;
			23: a = 32'h0000007F;
			24: a = 32'h0000003F;
			25: a = 32'h0000001F;
			26: a = 32'h0000000F;
			27: a = 32'h00000008;
			28: a = 32'h00000004;
			29: a = 32'h00000002;
			default: a = 32'h0;
		endcase
		return $signed({2'b00, a});
	endfunction

	// quarter-turn index, remainder and mirrored remainder of n/d of a turn
	function automatic prep_t turn_prep(input logic [7:0] n, input logic [8:0] d);
		logic [10:0] n4, d1, d2, d3, d4, r, t;
		prep_t       o;
		n4 = {1'b0, n, 2'b00};
		d1 = {2'b00, d};
		d2 = {1'b0, d, 1'b0};
		d3 = d1 + d2;
		d4 = {d, 2'b00};
		if (n4 >= d4) begin
			o.q = 2'd0;
			r   = n4 - d4;
		end else if (n4 >= d3) begin
			o.q = 2'd3;
			r   = n4 - d3;
		end else if (n4 >= d2) begin
			o.q = 2'd2;
			r   = n4 - d2;
		end else if (n4 >= d1) begin
			o.q = 2'd1;
			r   = n4 - d1;
		end else begin
			o.q = 2'd0;
			r   = n4;
		end
		o.zr = (r == 11'd0);
		o.sw = ({r[9:0], 1'b0} > d1);
		t    = o.sw ? (d1 - r) : r;
		o.t  = t[8:0];
		return o;
	endfunction

	// undo the octant reduction and place signs by quadrant
	function automatic trig_t trig_fix(input logic [30:0] c, input logic [30:0] s,
			input logic [1:0] q, input logic sw, input logic zr);
		logic [30:0] c0, s0;
		trig_t       o;
		if (zr) begin
			c0 = ONE_Q30;
			s0 = 31'd0;
		end else if (sw) begin
			c0 = s;
			s0 = c;
		end else begin
			c0 = c;
			s0 = s;
		end
		case (q)
			2'd0: o = '{cm: c0, cn: 1'b0, sm: s0, sn: 1'b0};
			2'd1: o = '{cm: s0, cn: 1'b1, sm: c0, sn: 1'b0};
			2'd2: o = '{cm: c0, cn: 1'b1, sm: s0, sn: 1'b1};
			default: o = '{cm: s0, cn: 1'b0, sm: c0, sn: 1'b1};
		endcase
		return o;
	endfunction

endpackage

[hdl/uvs_div.sv]
// pipelined restoring divider, a few quotient bits per stage
module uvs_div import uvs_pkg::*; #(
	parameter int NW   = 40,
	parameter int DW   = 9,
	parameter int QW   = 30,
	parameter int NSTG = 4
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int SPS = (QW + NSTG - 1) / NSTG;
	localparam int QP  = SPS * NSTG;
	localparam int XW  = QP + DW;

	logic [XW-1:0] numx;
	logic [DW-1:0] rem_i [NSTG];
	logic [QP-1:0] acc_i [NSTG];
	logic [DW-1:0] den_i [NSTG];
	logic [DW-1:0] rem_s [NSTG];
	logic [QP-1:0] acc_s [NSTG];
	logic [DW-1:0] den_s [NSTG];

	assign numx = XW'(num);

	genvar g;
	generate
		for (g = 0; g < NSTG; g++) begin : g_stage
			logic [DW-1:0] rem_c;
			logic [QP-1:0] acc_c;

			if (g == 0) begin : g_first
				assign rem_i[g] = numx[XW-1:QP];
				assign acc_i[g] = numx[QP-1:0];
				assign den_i[g] = den;
			end else begin : g_next
				assign rem_i[g] = rem_s[g-1];
				assign acc_i[g] = acc_s[g-1];
				assign den_i[g] = den_s[g-1];
			end

			// numerator bits shift out the top, quotient bits shift in below
			always_comb begin
				logic [DW:0] t;
				rem_c = rem_i[g];
				acc_c = acc_i[g];
				for (int j = 0; j < SPS; j++) begin
					t     = {rem_c, acc_c[QP-1]};
					acc_c = {acc_c[QP-2:0], 1'b0};
					if (t >= {1'b0, den_i[g]}) begin
						t        = t - {1'b0, den_i[g]};
						acc_c[0] = 1'b1;
					end
					rem_c = t[DW-1:0];
				end
			end

			always_ff @(posedge clk) begin
				rem_s[g] <= rem_c;
				acc_s[g] <= acc_c;
				den_s[g] <= den_i[g];
			end
		end
	endgenerate

	assign quo = acc_s[NSTG-1][QW-1:0];

endmodule

[hdl/uvs_cordic.sv]
// pipelined rotation-mode cordic, cos and sin magnitudes in q30
module uvs_cordic import uvs_pkg::*; (
	input  logic        clk,
	input  logic [29:0] angle,
	output logic [30:0] cos_mag,
	output logic [30:0] sin_mag
);

	cword_t x_i [CORD_STG];
	cword_t y_i [CORD_STG];
	cword_t z_i [CORD_STG];
	cword_t x_s [CORD_STG];
	cword_t y_s [CORD_STG];
	cword_t z_s [CORD_STG];

	function automatic logic [30:0] clamp_q30(input cword_t v);
		logic [30:0] o;
		if (v < 0)
			o = 31'd0;
		else if (v > $signed({3'b000, ONE_Q30}))
			o = ONE_Q30;
		else
			o = v[30:0];
		return o;
	endfunction

	genvar g;
	generate
		for (g = 0; g < CORD_STG; g++) begin : g_stage
			cword_t xc, yc, zc;

			if (g == 0) begin : g_first
				assign x_i[g] = CORD_GAIN;
				assign y_i[g] = '0;
				assign z_i[g] = $signed({4'b0000, angle});
			end else begin : g_next
				assign x_i[g] = x_s[g-1];
				assign y_i[g] = y_s[g-1];
				assign z_i[g] = z_s[g-1];
			end

			always_comb begin
				cword_t dx, dy;
				int     i;
				xc = x_i[g];
				yc = y_i[g];
				zc = z_i[g];
				for (int j = 0; j < CORD_IPS; j++) begin
					i  = g * CORD_IPS + j;
					dx = yc >>> i;
					dy = xc >>> i;
					if (!zc[CW-1]) begin
						xc = xc - dx;
						yc = yc + dy;
						zc = zc - atan_q30(i);
					end else begin
						xc = xc + dx;
						yc = yc - dy;
						zc = zc + atan_q30(i);
					end
				end
			end

			always_ff @(posedge clk) begin
				x_s[g] <= xc;
				y_s[g] <= yc;
				z_s[g] <= zc;
			end
		end
	endgenerate

	assign cos_mag = clamp_q30(x_s[CORD_STG-1]);
	assign sin_mag = clamp_q30(y_s[CORD_STG-1]);

endmodule

[hdl/uv_sphere_vertex_generator_unit.sv]
// top level: grid point to normal, position and triangle results
//
// A grid point is taken on start while busy is low; a new point can be taken every cycle
// until eight points are outstanding (accepted but not fully delivered). On its way to
// the result queue a point passes through the pipeline: three front stages,
// a four-stage divider for the angles and texture, a ten-stage cordic (three rotations per
// stage), and three stages for octant fixup, products and rounding. Results leave one per
// cycle on the result port, each marked by result_strobe for one cycle, so a point inside
// the grid gives four results (normal, position and two triangles), a point on the last
// row or column two, and an off-grid point one error result: this port limits the rate.
// The receiver cannot stall the port. Precision is written through the register port at
// byte address 0 and must only change while nothing is outstanding.
module uv_sphere_vertex_generator_unit import uvs_pkg::*; #(
	parameter int MAX_PRECISION = 255,
	parameter int FRAC_BITS     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        row,
	input  logic [7:0]        column,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic              result_strobe,
	output logic [1:0]        kind,
	output logic [18:0]       coord_x,
	output logic [18:0]       coord_y,
	output logic [18:0]       coord_z,
	output logic [16:0]       tex_u,
	output logic [16:0]       tex_v,
	output logic [15:0]       corner_a,
	output logic [15:0]       corner_b,
	output logic [15:0]       corner_c,
	output logic              last
);

	localparam int TNW      = 8 + FRAC_BITS;
	localparam int TQW      = FRAC_BITS + 1;
	localparam int MW       = FRAC_BITS + 1;
	localparam int SHP      = 2 * CQ - FRAC_BITS;
	localparam int SHC      = CQ - FRAC_BITS;
	localparam int SIDE_LAT = DIV_STG + CORD_STG;
	localparam int PIPE_LEN = 3 + DIV_STG + CORD_STG + 3;

	// register port
	logic [7:0] precision_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PRECISION);
	assign prdata = (paddr[2] == REG_PRECISION) ? {24'd0, precision_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= PREC_RESET;
		end else if (cfg_wr) begin
			precision_q <= pwdata[7:0];
		end
	end

	// flow control
	logic             accept;
	logic             pop;
	logic             push;
	logic [QCW-1:0]   out_cnt_q;
	logic [PIPE_LEN:1] vld_s;

	assign busy   = (out_cnt_q == QCW'(QDEPTH));
	assign accept = start && !busy;
	assign push   = vld_s[PIPE_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_cnt_q <= '0;
		end else begin
			vld_s     <= {vld_s[PIPE_LEN-1:1], accept};
			out_cnt_q <= out_cnt_q + QCW'(accept) - QCW'(pop);
		end
	end

	// stage 1: capture the point and classify it
	logic [7:0] row_s1, col_s1, p_s1;
	logic       err_s1, trg_s1;

	always_ff @(posedge clk) begin
		row_s1 <= row;
		col_s1 <= column;
		p_s1   <= precision_q;
		err_s1 <= (precision_q == 8'd0) || ({1'b0, precision_q} > 9'(MAX_PRECISION))
			|| (row > precision_q) || (column > precision_q);
		trg_s1 <= (row < precision_q) && (column < precision_q);
	end

	// stage 2: octant reduction, triangle base index
	prep_t       prep_a_s2, prep_b_s2;
	logic [7:0]  row_s2, col_s2, p_s2;
	logic        err_s2, trg_s2;
	logic [15:0] base_s2;
	logic [8:0]  w_s2;
	logic [8:0]  w1;

	assign w1 = {1'b0, p_s1} + 9'd1;

	always_ff @(posedge clk) begin
		prep_a_s2 <= turn_prep(row_s1, {p_s1, 1'b0});
		prep_b_s2 <= turn_prep(col_s1, {1'b0, p_s1});
		row_s2    <= row_s1;
		col_s2    <= col_s1;
		p_s2      <= p_s1;
		err_s2    <= err_s1;
		trg_s2    <= trg_s1;
		base_s2   <= 16'(row_s1) * 16'(w1) + {8'd0, col_s1};
		w_s2      <= w1;
	end

	// stage 3: divider operands
	logic [39:0]    anum_a_s3, anum_b_s3;
	logic [8:0]     aden_a_s3, aden_b_s3;
	logic [TNW-1:0] tnum_u_s3, tnum_v_s3;
	logic [7:0]     tden_s3;
	side_t          side_s3;
	logic [8:0]     da2, db2;

	assign da2 = {p_s2, 1'b0};
	assign db2 = {1'b0, p_s2};

	always_ff @(posedge clk) begin
		anum_a_s3 <= 40'(prep_a_s2.t) * 40'(HALF_PI_Q30) + 40'(da2 >> 1);
		anum_b_s3 <= 40'(prep_b_s2.t) * 40'(HALF_PI_Q30) + 40'(db2 >> 1);
		aden_a_s3 <= da2;
		aden_b_s3 <= db2;
		tnum_u_s3 <= (TNW'(col_s2) << FRAC_BITS) + TNW'(p_s2 >> 1);
		tnum_v_s3 <= (TNW'(row_s2) << FRAC_BITS) + TNW'(p_s2 >> 1);
		tden_s3   <= p_s2;
		side_s3   <= '{err: err_s2, trg: trg_s2, base: base_s2, w: w_s2,
			qa: prep_a_s2.q, swa: prep_a_s2.sw, za: prep_a_s2.zr,
			qb: prep_b_s2.q, swb: prep_b_s2.sw, zb: prep_b_s2.zr};
	end

	// dividers
	logic [29:0]    ang_a, ang_b;
	logic [TQW-1:0] tq_u, tq_v;

	uvs_div #(.NW(40), .DW(9), .QW(30), .NSTG(DIV_STG)) u_div_a (
		.clk (clk), .num (anum_a_s3), .den (aden_a_s3), .quo (ang_a)
	);
	uvs_div #(.NW(40), .DW(9), .QW(30), .NSTG(DIV_STG)) u_div_b (
		.clk (clk), .num (anum_b_s3), .den (aden_b_s3), .quo (ang_b)
	);
	uvs_div #(.NW(TNW), .DW(8), .QW(TQW), .NSTG(DIV_STG)) u_div_u (
		.clk (clk), .num (tnum_u_s3), .den (tden_s3), .quo (tq_u)
	);
	uvs_div #(.NW(TNW), .DW(8), .QW(TQW), .NSTG(DIV_STG)) u_div_v (
		.clk (clk), .num (tnum_v_s3), .den (tden_s3), .quo (tq_v)
	);

	// cordics
	logic [30:0] ca_raw, sa_raw, cb_raw, sb_raw;

	uvs_cordic u_cordic_a (.clk (clk), .angle (ang_a), .cos_mag (ca_raw), .sin_mag (sa_raw));
	uvs_cordic u_cordic_b (.clk (clk), .angle (ang_b), .cos_mag (cb_raw), .sin_mag (sb_raw));

	// side data and texture wait out the divider and cordic
	side_t       side_dl_s [SIDE_LAT];
	logic [16:0] tu_dl_s [CORD_STG];
	logic [16:0] tv_dl_s [CORD_STG];

	always_ff @(posedge clk) begin
		side_dl_s[0] <= side_s3;
		for (int k = 1; k < SIDE_LAT; k++)
			side_dl_s[k] <= side_dl_s[k-1];
		tu_dl_s[0] <= 17'(tq_u);
		tv_dl_s[0] <= 17'(tq_v);
		for (int k = 1; k < CORD_STG; k++) begin
			tu_dl_s[k] <= tu_dl_s[k-1];
			tv_dl_s[k] <= tv_dl_s[k-1];
		end
	end

	// stage 18: octant fixup
	trig_t       ta_s18, tb_s18;
	side_t       side_s18;
	logic [16:0] tu_s18, tv_s18;
	side_t       side_end;

	assign side_end = side_dl_s[SIDE_LAT-1];

	always_ff @(posedge clk) begin
		ta_s18   <= trig_fix(ca_raw, sa_raw, side_end.qa, side_end.swa, side_end.za);
		tb_s18   <= trig_fix(cb_raw, sb_raw, side_end.qb, side_end.swb, side_end.zb);
		side_s18 <= side_end;
		tu_s18   <= tu_dl_s[CORD_STG-1];
		tv_s18   <= tv_dl_s[CORD_STG-1];
	end

	// stage 19: products
	logic [61:0] prx_s19, prz_s19;
	logic [30:0] ca_s19;
	logic        nxn_s19, nyn_s19, nzn_s19;
	side_t       side_s19;
	logic [16:0] tu_s19, tv_s19;

	always_ff @(posedge clk) begin
		prx_s19  <= 62'(ta_s18.sm) * 62'(tb_s18.cm);
		prz_s19  <= 62'(ta_s18.sm) * 62'(tb_s18.sm);
		ca_s19   <= ta_s18.cm;
		nxn_s19  <= !tb_s18.cn;
		nyn_s19  <= !ta_s18.cn;
		nzn_s19  <= tb_s18.sn;
		side_s19 <= side_s18;
		tu_s19   <= tu_s18;
		tv_s19   <= tv_s18;
	end

	// stage 20: round to output precision, ties away from zero on the magnitude
	logic [MW-1:0] mx_s20, my_s20, mz_s20;
	logic          nxn_s20, nyn_s20, nzn_s20;
	side_t         side_s20;
	logic [16:0]   tu_s20, tv_s20;

	always_ff @(posedge clk) begin
		mx_s20   <= MW'(({1'b0, prx_s19} + (63'd1 << (SHP - 1))) >> SHP);
		mz_s20   <= MW'(({1'b0, prz_s19} + (63'd1 << (SHP - 1))) >> SHP);
		my_s20   <= MW'(({1'b0, ca_s19} + (32'd1 << (SHC - 1))) >> SHC);
		nxn_s20  <= nxn_s19;
		nyn_s20  <= nyn_s19;
		nzn_s20  <= nzn_s19;
		side_s20 <= side_s19;
		tu_s20   <= tu_s19;
		tv_s20   <= tv_s19;
	end

	function automatic logic [18:0] enc(input logic [18:0] m, input logic n);
		return n ? (19'd0 - m) : m;
	endfunction

	logic [18:0] mx19, my19, mz19;
	res_t        ent;

	assign mx19 = 19'(mx_s20);
	assign my19 = 19'(my_s20);
	assign mz19 = 19'(mz_s20);

	always_comb begin
		ent.err  = side_s20.err;
		ent.trg  = side_s20.trg;
		ent.nx   = enc(mx19, nxn_s20);
		ent.ny   = enc(my19, nyn_s20);
		ent.nz   = enc(mz19, nzn_s20);
		ent.px   = enc(mx19 + {mx19[17:0], 1'b0}, nxn_s20);
		ent.py   = enc(my19 + {my19[17:0], 1'b0}, nyn_s20);
		ent.pz   = enc(mz19 + {mz19[17:0], 1'b0}, nzn_s20);
		ent.tu   = tu_s20;
		ent.tv   = tv_s20;
		ent.base = side_s20.base;
		ent.w    = side_s20.w;
	end

	// result queue, one entry per point
	res_t           q_mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] fill_q;
	beat_t          beat_q, beat_d;
	res_t           head;

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			beat_q   <= BEAT_NORMAL;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push);
			rd_ptr_q <= rd_ptr_q + QAW'(pop);
			fill_q   <= fill_q + QCW'(push) - QCW'(pop);
			beat_q   <= beat_d;
		end
	end

	assign head          = q_mem_q[rd_ptr_q];
	assign result_strobe = (fill_q != '0);
	assign pop           = result_strobe && last;

	// next beat
	always_comb begin
		beat_d = beat_q;
		if (pop) begin
			beat_d = BEAT_NORMAL;
		end else if (result_strobe) begin
			case (beat_q)
				BEAT_NORMAL:   beat_d = BEAT_POSITION;
				BEAT_POSITION: beat_d = BEAT_TRI_LO;
				BEAT_TRI_LO:   beat_d = BEAT_TRI_HI;
				default:       beat_d = BEAT_NORMAL;
			endcase
		end
	end

	// beat payload
	logic [15:0] b1, bw, bw1;
	kind_t       kind_w;

	assign b1  = head.base + 16'd1;
	assign bw  = head.base + {7'd0, head.w};
	assign bw1 = bw + 16'd1;
	assign kind = kind_w;

	always_comb begin
		kind_w   = KIND_NORMAL;
		coord_x  = '0;
		coord_y  = '0;
		coord_z  = '0;
		tex_u    = '0;
		tex_v    = '0;
		corner_a = '0;
		corner_b = '0;
		corner_c = '0;
		last     = 1'b0;
		if (result_strobe) begin
			if (head.err) begin
				kind_w = KIND_ERROR;
				last   = 1'b1;
			end else begin
				case (beat_q)
					BEAT_NORMAL: begin
						kind_w  = KIND_NORMAL;
						coord_x = head.nx;
						coord_y = head.ny;
						coord_z = head.nz;
						tex_u   = head.tu;
						tex_v   = head.tv;
					end
					BEAT_POSITION: begin
						kind_w  = KIND_POSITION;
						coord_x = head.px;
						coord_y = head.py;
						coord_z = head.pz;
						last    = !head.trg;
					end
					BEAT_TRI_LO: begin
						kind_w   = KIND_TRIANGLE;
						corner_a = head.base;
						corner_b = b1;
						corner_c = bw;
					end
					default: begin
						kind_w   = KIND_TRIANGLE;
						corner_a = b1;
						corner_b = bw1;
						corner_c = bw;
						last     = 1'b1;
					end
				endcase
			end
		end
	end

	// queue entries never outnumber the points still owed
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= out_cnt_q)
		else $error("result queue holds more points than are outstanding");

	assert property (@(posedge clk) disable iff (!arst_n) out_cnt_q <= QCW'(QDEPTH))
		else $error("outstanding point count exceeds queue depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fill_q < QCW'(QDEPTH))
		else $error("push into a full result queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != BEAT_NORMAL |-> fill_q != '0)
		else $error("beat in progress with empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind_w == KIND_ERROR |-> last)
		else $error("error beat not marked last");

endmodule

[test/testbench.sv]
// testbench for the uv sphere vertex generator: directed and random grid points checked against a predictor
`timescale 1ns / 1ps

module testbench;
	import uvs_pkg::*;

	localparam longint ONE_Q = 64'd1073741824;
	localparam longint HALF_PI_Q = 64'd1686629713;
	localparam longint GAIN_Q = 64'd652032874;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [ADDR_W-1:0] ADDR_PRECISION = ADDR_W'(4 * REG_PRECISION);
	localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(4);
	localparam longint ATAN_Q [30] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
		64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	typedef struct packed {
		kind_t       kind;
		logic [18:0] x;
		logic [18:0] y;
		logic [18:0] z;
		logic [16:0] u;
		logic [16:0] v;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic        last;
	} vtx_beat_t;

	class vertex_scoreboard;
		logic [7:0] precision;
		vtx_beat_t  pending_beats[$];
		int         mismatches;

		function new();
			precision = PREC_RESET;
			mismatches = 0;
		endfunction

		function automatic longint clamp_unit(longint v);
			if (v < 0)
				return 0;
			if (v > ONE_Q)
				return ONE_Q;
			return v;
		endfunction

		// rotation mode, cos and sin magnitudes in Q30
		function automatic void rotate(longint ang, output longint c, output longint s);
			longint x, y, z, dx, dy;
			x = GAIN_Q;
			y = 0;
			z = ang;
			for (int i = 0; i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN_Q[i];
				end else begin
					x += dx; y -= dy; z += ATAN_Q[i];
				end
			end
			c = clamp_unit(x);
			s = clamp_unit(y);
		endfunction

		// cos and sin of n/d of a turn
		function automatic void turn_angle(longint n, longint d, output longint cm,
				output bit cn, output longint sm, output bit sn);
			longint q, r, c0, s0;
			q = (4 * n) / d;
			r = 4 * n - q * d;
			if (r == 0) begin
				c0 = ONE_Q; s0 = 0;
			end else if (2 * r > d) begin
				rotate(((d - r) * HALF_PI_Q + d / 2) / d, s0, c0);
			end else begin
				rotate((r * HALF_PI_Q + d / 2) / d, c0, s0);
			end
			case (q & 3)
				0: begin cm = c0; cn = 0; sm = s0; sn = 0; end
				1: begin cm = s0; cn = 1; sm = c0; sn = 0; end
				2: begin cm = c0; cn = 1; sm = s0; sn = 1; end
				default: begin cm = s0; cn = 0; sm = c0; sn = 1; end
			endcase
		endfunction

		function automatic logic [18:0] signed_coord(longint mag, bit neg);
			return neg ? 19'(-mag) : 19'(mag);
		endfunction

		function automatic void note_point(logic [7:0] r, logic [7:0] col);
			longint p, ca, sa, cb, sb, mx, my, mz, base, w;
			bit can, san, cbn, sbn;
			vtx_beat_t e;
			p = precision;
			e = '0;
			if (p == 0 || r > p || col > p) begin
				e.kind = KIND_ERROR;
				e.last = 1;
				pending_beats.push_back(e);
				return;
			end
			turn_angle(r, 2 * p, ca, can, sa, san);
			turn_angle(col, p, cb, cbn, sb, sbn);
			my = (ca + (64'd1 << 13)) >> 14;
			mx = longint'((64'(sa) * 64'(cb) + (64'd1 << 43)) >> 44);
			mz = longint'((64'(sa) * 64'(sb) + (64'd1 << 43)) >> 44);
			e.kind = KIND_NORMAL;
			e.x = signed_coord(mx, !cbn);
			e.y = signed_coord(my, !can);
			e.z = signed_coord(mz, sbn);
			e.u = 17'(((longint'(col) << 16) + p / 2) / p);
			e.v = 17'(((longint'(r) << 16) + p / 2) / p);
			pending_beats.push_back(e);
			e = '0;
			e.kind = KIND_POSITION;
			e.x = signed_coord(3 * mx, !cbn);
			e.y = signed_coord(3 * my, !can);
			e.z = signed_coord(3 * mz, sbn);
			if (r >= p || col >= p) begin
				e.last = 1;
				pending_beats.push_back(e);
				return;
			end
			pending_beats.push_back(e);
			w = p + 1;
			base = r * w + col;
			e = '0;
			e.kind = KIND_TRIANGLE;
			e.a = 16'(base); e.b = 16'(base + 1); e.c = 16'(base + w);
			pending_beats.push_back(e);
			e.a = 16'(base + 1); e.b = 16'(base + w + 1); e.c = 16'(base + w);
			e.last = 1;
			pending_beats.push_back(e);
		endfunction

		function automatic void check_beat(vtx_beat_t got);
			vtx_beat_t e;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %p", got);
				return;
			end
			e = pending_beats.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch (precision %0d)\n  expected %p\n  actual   %p",
						precision, e, got);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, psel, penable, pwrite, pready, result_strobe, last;
	logic [7:0] row, column;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic [1:0] kind;
	logic [18:0] coord_x, coord_y, coord_z;
	logic [16:0] tex_u, tex_v;
	logic [15:0] corner_a, corner_b, corner_c;

	vertex_scoreboard sb = new();
	int idle_cycles = 0;

	uv_sphere_vertex_generator_unit DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_strobe)
				sb.check_beat('{kind_t'(kind), coord_x, coord_y, coord_z, tex_u, tex_v,
					corner_a, corner_b, corner_c, last});
			if (result_strobe || (start && !busy))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_point(logic [7:0] r, logic [7:0] col);
		@(negedge clk);
		start <= 1;
		row <= r;
		column <= col;
		do @(posedge clk); while (busy);
		sb.note_point(r, col);
	endtask

	task automatic pause_sender(int n);
		@(negedge clk);
		start <= 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		pause_sender(0);
		while (sb.pending_beats.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_PRECISION)
			sb.precision = data[7:0];
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic random_points(int n);
		int burst;
		logic [7:0] p, r, col;
		burst = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			p = sb.precision;
			if ($urandom_range(0, 99) < 85) begin
				r = $urandom_range(0, p);
				col = $urandom_range(0, p);
			end else begin
				r = $urandom_range(0, 255);
				col = $urandom_range(0, 255);
			end
			send_point(r, col);
			if (i == n / 2)
				drain();
			else if (--burst == 0) begin
				if ($urandom_range(0, 2) != 0)
					pause_sender($urandom_range(1, 10));
				burst = $urandom_range(1, 12);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0; row = 0; column = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset precision: poles, seams, off-grid points
		send_point(0, 0);
		send_point(48, 48);
		send_point(48, 0);
		send_point(0, 48);
		send_point(24, 12);
		send_point(12, 36);
		send_point(49, 0);
		send_point(0, 49);
		send_point(255, 255);
		send_point(47, 47);
		drain();
		write_reg(ADDR_PRECISION, 32'd255);
		send_point(255, 255);
		send_point(254, 254);
		send_point(170, 85);
		send_point(0, 0);
		drain();
		write_reg(ADDR_PRECISION, 32'd1);
		send_point(0, 0);
		send_point(1, 1);
		send_point(2, 0);
		drain();
		// zero precision turns every point into an error
		write_reg(ADDR_PRECISION, 32'd0);
		send_point(0, 0);
		send_point(8'hAA, 8'h55);
		drain();

		random_points(10);
		drain();
		write_reg(ADDR_PRECISION, 32'd48);
		random_points(70);
		drain();
		write_reg(ADDR_PRECISION, 32'd255);
		random_points(80);
		drain();
		write_reg(ADDR_PRECISION, 32'd1);
		random_points(40);
		drain();
		// only the low byte is kept
		write_reg(ADDR_PRECISION, 32'hFFFFFF05);
		random_points(60);
		drain();
		// write outside the register map leaves precision alone
		write_reg(ADDR_UNUSED, 32'hFFFFFFFF);
		random_points(40);
		drain();
		write_reg(ADDR_PRECISION, 32'd100);
		random_points(70);
		drain();
		write_reg(ADDR_PRECISION, 32'd13);
		random_points(40);
		drain();

		if (sb.mismatches == 0 && sb.pending_beats.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
hdl/uvs_pkg.sv
hdl/uvs_div.sv
hdl/uvs_cordic.sv
hdl/uv_sphere_vertex_generator_unit.sv
test/testbench.sv
